[sv/tcr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcr_pkg: shared definitions for the tetrahedron circumradius alpha test
// Holds the default coordinate width, the alpha register width, the limb size
// of the pipelined multipliers and the outcome codes.
// ---------------------------------------------------------------------------
package tcr_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int ALPHA_WIDTH     = 48;

    // Width of one limb in the limb-serial multipliers.
    localparam int MUL_LIMB        = 32;

    typedef logic [1:0] outcome_t;

    localparam outcome_t OUTCOME_NOT_BELOW  = 2'd0;
    localparam outcome_t OUTCOME_BELOW      = 2'd1;
    localparam outcome_t OUTCOME_DEGENERATE = 2'd2;

endpackage

[sv/tcr_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcr_if: valid/ready channels of the circumradius test
// tcr_in_if carries the twelve vertex coordinates of one tetrahedron,
// tcr_out_if carries the outcome code of one test.
// ---------------------------------------------------------------------------
interface tcr_in_if
    import tcr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] az;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic signed [COORD_WIDTH-1:0] bz;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] cz;
    logic signed [COORD_WIDTH-1:0] dx;
    logic signed [COORD_WIDTH-1:0] dy;
    logic signed [COORD_WIDTH-1:0] dz;

    modport source (
        output valid, ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz,
        input  ready
    );

    modport sink (
        input  valid, ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz,
        output ready
    );
endinterface

interface tcr_out_if
    import tcr_pkg::*;
();
    logic     valid;
    logic     ready;
    outcome_t outcome;

    modport source (
        output valid, outcome,
        input  ready
    );

    modport sink (
        input  valid, outcome,
        output ready
    );
endinterface

[sv/tetra_circumradius_alpha_test_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tetra_circumradius_alpha_test_core: alpha-shape circumradius test
// Decides for one tetrahedron whether its squared circumradius lies strictly
// below a configured alpha, in exact integer arithmetic and without division.
// ---------------------------------------------------------------------------
//
//  Channel     Direction  Handshake      Payload
//  ---------   ---------  -------------  ------------------------------------
//  vertices    in         valid / ready  ax..dz, four signed vertices
//  result      out        valid / ready  outcome (not below, below, degenerate)
//  cfg_wr_*    in         write enable   alpha_squared_radius, 48 bits
//
//  One item enters per cycle while the skid register is empty, and every item
//  gives one result. The pipeline runs through four rows of limb-serial
//  multipliers.
//  Reset clears the valid bits, the output and skid valid flags and alpha.
//  All stages share one enable that drops only while the skid register is
//  full, so a stalled sink freezes the pipeline without losing an item, and
//  the block keeps accepting items while one result waits at the output.
// ---------------------------------------------------------------------------
module tetra_circumradius_alpha_test_core
    import tcr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [ALPHA_WIDTH-1:0] cfg_wr_data,
    tcr_in_if.sink                 vertices,
    tcr_out_if.source              result
);

    // Widths of the exact intermediates. Edges are differences of two
    // coordinates; every later width follows from that one.
    localparam int EW  = COORD_WIDTH + 1;   // edge vector component
    localparam int SQW = 2 * EW;            // edge component times edge component
    localparam int LW  = SQW + 2;           // squared edge length
    localparam int MW  = SQW + 1;           // 2x2 minor
    localparam int TW  = MW + LW;           // minor times third column
    localparam int DW  = TW + 2;            // 3x3 determinant
    localparam int QW  = 2 * DW;            // squared determinant
    localparam int NW  = QW + 2;            // sum of three squared numerators
    localparam int AW4 = ALPHA_WIDTH + 3;   // 4 * alpha as a signed value
    localparam int XW  = AW4 + QW;          // alpha * 4 * den^2

    // Multiplier latencies, one per multiplier row.
    localparam int LAT2 = (EW  + MUL_LIMB - 1) / MUL_LIMB + 3;
    localparam int LAT4 = (MW  + MUL_LIMB - 1) / MUL_LIMB + 3;
    localparam int LAT6 = (DW  + MUL_LIMB - 1) / MUL_LIMB + 3;
    localparam int LAT8 = (AW4 + MUL_LIMB - 1) / MUL_LIMB + 3;

    // Stages from acceptance to the final outcome register.
    localparam int TOTAL = 4 + LAT2 + LAT4 + LAT6 + LAT8;

    logic                   en;
    logic                   in_fire;

    logic [ALPHA_WIDTH-1:0] alpha_reg;
    logic signed [AW4-1:0]  alpha4;

    logic [TOTAL-1:0]       v_reg;

    logic signed [COORD_WIDTH-1:0] crd [4][3];

    logic signed [EW-1:0]   e_reg       [3][3];
    logic signed [EW-1:0]   ez_pipe_reg [LAT2][3];

    logic signed [SQW-1:0]  sq   [3][3];
    logic signed [SQW-1:0]  mp_f [3][3];
    logic signed [SQW-1:0]  mp_g [3][3];

    logic signed [LW-1:0]   l2_reg    [3];
    logic signed [MW-1:0]   minor_reg [3][3];
    logic signed [EW-1:0]   ez3_reg   [3];

    logic signed [TW-1:0]   term    [4][3];
    logic signed [DW-1:0]   det_reg [4];
    logic signed [QW-1:0]   sqd     [4];

    logic signed [NW-1:0]   nom_pipe_reg [LAT8];
    logic                   deg_pipe_reg [LAT8];
    logic signed [XW-1:0]   bound;

    outcome_t               outcome_reg;
    logic                   p_valid;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    outcome_t               out_outcome_reg;
    logic                   skid_valid_reg;
    logic                   skid_valid_next;
    outcome_t               skid_outcome_reg;
    logic                   load_out;
    logic                   load_skid;
    logic                   out_from_skid;

    // ------------------------------------------------------------------
    // Handshake and configuration.
    // ------------------------------------------------------------------
    assign en             = !skid_valid_reg;
    assign vertices.ready = en;
    assign in_fire        = vertices.valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alpha_reg <= '0;
        else if (cfg_wr_en)
            alpha_reg <= cfg_wr_data;
    end

    assign alpha4 = {1'b0, alpha_reg, 2'b00};

    // Valid bits travel with the data through every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[TOTAL-2:0], in_fire};
    end

    assign p_valid = v_reg[TOTAL-1];

    // ------------------------------------------------------------------
    // Stage 1: edge vectors from vertex 0.
    // ------------------------------------------------------------------
    assign crd[0][0] = vertices.ax;
    assign crd[0][1] = vertices.ay;
    assign crd[0][2] = vertices.az;
    assign crd[1][0] = vertices.bx;
    assign crd[1][1] = vertices.by;
    assign crd[1][2] = vertices.bz;
    assign crd[2][0] = vertices.cx;
    assign crd[2][1] = vertices.cy;
    assign crd[2][2] = vertices.cz;
    assign crd[3][0] = vertices.dx;
    assign crd[3][1] = vertices.dy;
    assign crd[3][2] = vertices.dz;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                    e_reg[k][i] <= EW'(crd[k+1][i]) - EW'(crd[0][i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Multiplier row 1: squares of the edge components and the products
    // that form the 2x2 minors. Pair 0 is (y, z), pair 1 is (x, z) and
    // pair 2 is (x, y); row pairs are (0, 1), (0, 2) and (1, 2).
    // ------------------------------------------------------------------
    for (genvar k = 0; k < 3; k++)
    begin : g_sq_row
        for (genvar i = 0; i < 3; i++)
        begin : g_sq_col
            tcr_mul #(.AW(EW), .BW(EW)) u_sq
            (
                .clk (clk),
                .en  (en),
                .a   (e_reg[k][i]),
                .b   (e_reg[k][i]),
                .p   (sq[k][i])
            );
        end
    end

    for (genvar pi = 0; pi < 3; pi++)
    begin : g_mn_pair
        localparam int C0 = (pi == 0) ? 1 : 0;
        localparam int C1 = (pi == 2) ? 1 : 2;
        for (genvar ri = 0; ri < 3; ri++)
        begin : g_mn_rows
            localparam int R0 = (ri == 2) ? 1 : 0;
            localparam int R1 = (ri == 0) ? 1 : 2;

            tcr_mul #(.AW(EW), .BW(EW)) u_mf
            (
                .clk (clk),
                .en  (en),
                .a   (e_reg[R0][C0]),
                .b   (e_reg[R1][C1]),
                .p   (mp_f[pi][ri])
            );

            tcr_mul #(.AW(EW), .BW(EW)) u_mg
            (
                .clk (clk),
                .en  (en),
                .a   (e_reg[R1][C0]),
                .b   (e_reg[R0][C1]),
                .p   (mp_g[pi][ri])
            );
        end
    end

    // The z components are needed again as the third column of the volume
    // determinant, so they ride along with the first multiplier row.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                ez_pipe_reg[0][r] <= e_reg[r][2];
            for (int s = 1; s < LAT2; s++)
                ez_pipe_reg[s] <= ez_pipe_reg[s-1];
        end
    end

    // ------------------------------------------------------------------
    // Squared edge lengths and 2x2 minors.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                l2_reg[k] <= LW'(sq[k][0]) + LW'(sq[k][1]) + LW'(sq[k][2]);
                ez3_reg[k] <= ez_pipe_reg[LAT2-1][k];
            end
            for (int pi = 0; pi < 3; pi++)
            begin
                for (int ri = 0; ri < 3; ri++)
                    minor_reg[pi][ri] <= MW'(mp_f[pi][ri]) - MW'(mp_g[pi][ri]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Multiplier row 2: each minor times the third column entry of the row
    // it leaves out. Determinants 0..2 are the numerator minors with the
    // squared lengths as third column, determinant 3 is the volume.
    // ------------------------------------------------------------------
    for (genvar di = 0; di < 4; di++)
    begin : g_det
        localparam int PI = (di == 3) ? 2 : di;
        for (genvar ri = 0; ri < 3; ri++)
        begin : g_term
            logic signed [LW-1:0] col;

            if (di == 3)
            begin : g_vol
                assign col = LW'(ez3_reg[2-ri]);
            end
            else
            begin : g_num
                assign col = l2_reg[2-ri];
            end

            tcr_mul #(.AW(MW), .BW(LW)) u_term
            (
                .clk (clk),
                .en  (en),
                .a   (minor_reg[PI][ri]),
                .b   (col),
                .p   (term[di][ri])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int di = 0; di < 4; di++)
                det_reg[di] <= DW'(term[di][0]) - DW'(term[di][1]) + DW'(term[di][2]);
        end
    end

    // ------------------------------------------------------------------
    // Multiplier row 3: squares of the four determinants.
    // ------------------------------------------------------------------
    for (genvar di = 0; di < 4; di++)
    begin : g_dsq
        tcr_mul #(.AW(DW), .BW(DW)) u_dsq
        (
            .clk (clk),
            .en  (en),
            .a   (det_reg[di]),
            .b   (det_reg[di]),
            .p   (sqd[di])
        );
    end

    // ------------------------------------------------------------------
    // Multiplier row 4: 4 * alpha * den^2. Meanwhile the numerator sum and
    // the degenerate flag wait in a delay line of the same length. The
    // tetrahedron is degenerate when all four determinants are zero.
    // ------------------------------------------------------------------
    tcr_mul #(.AW(AW4), .BW(QW)) u_bound
    (
        .clk (clk),
        .en  (en),
        .a   (alpha4),
        .b   (sqd[3]),
        .p   (bound)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nom_pipe_reg[0] <= NW'(sqd[0]) + NW'(sqd[1]) + NW'(sqd[2]);
            deg_pipe_reg[0] <= ((sqd[0] | sqd[1] | sqd[2] | sqd[3]) == '0);
            for (int s = 1; s < LAT8; s++)
            begin
                nom_pipe_reg[s] <= nom_pipe_reg[s-1];
                deg_pipe_reg[s] <= deg_pipe_reg[s-1];
            end
        end
    end

    // Final compare. A flat tetrahedron with a nonzero numerator has a zero
    // bound and so is never below alpha.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (deg_pipe_reg[LAT8-1])
                outcome_reg <= OUTCOME_DEGENERATE;
            else if (XW'(nom_pipe_reg[LAT8-1]) < bound)
                outcome_reg <= OUTCOME_BELOW;
            else
                outcome_reg <= OUTCOME_NOT_BELOW;
        end
    end

    // ------------------------------------------------------------------
    // Output register with a skid register behind it. The skid register
    // catches the item that leaves the pipeline in the cycle the sink stalls.
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_from_skid   = 1'b0;
        if (skid_valid_reg)
        begin
            if (result.ready)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
                out_from_skid   = 1'b1;
            end
        end
        else if (out_valid_reg && !result.ready)
        begin
            if (p_valid)
            begin
                skid_valid_next = 1'b1;
                load_skid       = 1'b1;
            end
        end
        else
        begin
            out_valid_next = p_valid;
            load_out       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_from_skid)
            out_outcome_reg <= skid_outcome_reg;
        else if (load_out)
            out_outcome_reg <= outcome_reg;
        if (load_skid)
            skid_outcome_reg <= outcome_reg;
    end

    assign result.valid   = out_valid_reg;
    assign result.outcome = out_outcome_reg;

endmodule

[sv/tcr_mul.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcr_mul: pipelined signed multiplier built from limb products
// The magnitudes are split into limbs. Each stage forms one row of limb
// products of A against all of B and adds the previous row into the
// accumulator; the sign is applied in the last stage.
// ---------------------------------------------------------------------------
module tcr_mul
    import tcr_pkg::*;
#(
    parameter int AW = 32,
    parameter int BW = 32
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int NA   = (AW + MUL_LIMB - 1) / MUL_LIMB;
    localparam int NB   = (BW + MUL_LIMB - 1) / MUL_LIMB;
    localparam int AP   = NA * MUL_LIMB;
    localparam int BP   = NB * MUL_LIMB;
    localparam int RW   = BP + MUL_LIMB;
    localparam int ACCW = AP + BP;
    localparam int PW   = AW + BW;
    localparam int NS   = NA + 2;

    logic [AW-1:0]   a_abs;
    logic [BW-1:0]   b_abs;

    logic [AP-1:0]   a_reg   [NS];
    logic [BP-1:0]   b_reg   [NS];
    logic            neg_reg [NS];
    logic [RW-1:0]   ev_reg  [NS];
    logic [RW-1:0]   od_reg  [NS];
    logic [ACCW-1:0] acc_reg [NS];
    logic signed [PW-1:0] p_reg;

    always_comb
    begin
        a_abs = a[AW-1] ? AW'(-a) : AW'(a);
        b_abs = b[BW-1] ? BW'(-b) : BW'(b);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0]   <= AP'(a_abs);
            b_reg[0]   <= BP'(b_abs);
            neg_reg[0] <= a[AW-1] ^ b[BW-1];
            ev_reg[0]  <= '0;
            od_reg[0]  <= '0;
            acc_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k < NS; k++)
    begin : g_stage
        // Row of A limb k-1 is formed here; row k-2 is added to the sum.
        localparam int R  = k - 1;
        localparam int RI = (R < NA) ? R : 0;
        localparam int SH = (k >= 2) ? (k - 2) * MUL_LIMB : 0;

        logic [RW-1:0]   ev_next;
        logic [RW-1:0]   od_next;
        logic [ACCW-1:0] acc_next;

        always_comb
        begin
            logic [MUL_LIMB-1:0]   a_limb;
            logic [2*MUL_LIMB-1:0] prod;
            ev_next = '0;
            od_next = '0;
            a_limb  = (R < NA) ? a_reg[k-1][RI*MUL_LIMB +: MUL_LIMB] : '0;
            for (int j = 0; j < NB; j++)
            begin
                prod = a_limb * b_reg[k-1][j*MUL_LIMB +: MUL_LIMB];
                // Even and odd limb products do not overlap among themselves.
                if (j[0])
                    od_next[j*MUL_LIMB +: 2*MUL_LIMB] = prod;
                else
                    ev_next[j*MUL_LIMB +: 2*MUL_LIMB] = prod;
            end
            acc_next = acc_reg[k-1] + (ACCW'(ev_reg[k-1]) << SH)
                                    + (ACCW'(od_reg[k-1]) << SH);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_reg[k]   <= a_reg[k-1];
                b_reg[k]   <= b_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ev_reg[k]  <= ev_next;
                od_reg[k]  <= od_next;
                acc_reg[k] <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_reg[NS-1])
                p_reg <= -$signed(PW'(acc_reg[NS-1]));
            else
                p_reg <= $signed(PW'(acc_reg[NS-1]));
        end
    end

    assign p = p_reg;

endmodule
